### rtl/core/alpha_levels_remap_unit_macros.svh
// assertion macros used by the checker of the alpha levels remap unit
`ifndef ALPHA_LEVELS_REMAP_UNIT_MACROS_SVH
`define ALPHA_LEVELS_REMAP_UNIT_MACROS_SVH

// clocked property, ignored while reset is low
`define ALRU_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked property that also holds across reset
`define ALRU_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/alru_pkg.sv
// shared constants and types of the alpha levels remap unit
package alru_pkg;

    // configuration bus sizes
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    // register index, taken from paddr[3:2]
    typedef enum logic [1:0] {
        REG_LEVEL_LO      = 2'd0,
        REG_LEVEL_HI      = 2'd1,
        REG_PREMULTIPLIED = 2'd2,
        REG_UNUSED        = 2'd3
    } t_reg_idx;

endpackage

### rtl/core/alpha_levels_remap_unit.sv
// alpha levels remap with optional unpremultiply and repremultiply, deep pipeline
//
//   channel | direction | handshake          | word
//   --------+-----------+--------------------+--------------------------------------
//   pixel   | in        | i_valid / o_stall  | i_red_in i_green_in i_blue_in i_alpha_in
//   result  | out       | o_valid / i_stall  | o_red_out o_green_out o_blue_out o_alpha_out
//   config  | in        | apb psel / penable | level low, level high, premultiplied
//
// one word per cycle while i_stall does not hold the output word; the pipeline depth is
// set by two restoring dividers that retire one quotient bit per stage:
// FRAC_BITS + 1 stages for the alpha ratio and CHANNEL_BITS stages for color
// i_rst_n is synchronous; it clears the valid bits and loads the register defaults
// when the output word is held by i_stall the whole pipeline holds and o_stall rises
module alpha_levels_remap_unit #(
    parameter int CHANNEL_BITS = 16,
    parameter int FRAC_BITS    = 12
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // apb configuration
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [alru_pkg::PADDR_W-1:0]       paddr,
    input  logic [alru_pkg::PDATA_W-1:0]       pwdata,
    output logic [alru_pkg::PDATA_W-1:0]       prdata,
    output logic                               pready,
    // pixel input
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic signed [CHANNEL_BITS-1:0]     i_red_in,
    input  logic signed [CHANNEL_BITS-1:0]     i_green_in,
    input  logic signed [CHANNEL_BITS-1:0]     i_blue_in,
    input  logic signed [CHANNEL_BITS-1:0]     i_alpha_in,
    // pixel output
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic signed [CHANNEL_BITS-1:0]     o_red_out,
    output logic signed [CHANNEL_BITS-1:0]     o_green_out,
    output logic signed [CHANNEL_BITS-1:0]     o_blue_out,
    output logic [FRAC_BITS:0]                 o_alpha_out
);
    import alru_pkg::*;

    localparam int C   = CHANNEL_BITS;
    localparam int F   = FRAC_BITS;
    localparam int LW  = F + 1;                      // level width
    localparam int QA  = F + 1;                      // alpha quotient bits
    localparam int ANW = LW + F + 2;                 // alpha numerator width
    localparam int EW  = ((C > LW) ? C : LW) + 2;    // compare width for alpha
    localparam int MW  = C + LW;                     // color product width
    localparam int CNW = MW + 2;                     // color numerator width
    localparam int SW  = ((CNW > 2 * C + 1) ? CNW : 2 * C + 1) + 1;

    localparam logic [LW-1:0] ONE_VAL = LW'(1) << F;
    localparam logic [C-1:0]  CH_MAX  = {1'b0, {(C - 1){1'b1}}};
    localparam logic [C-1:0]  CH_MIN  = {1'b1, {(C - 1){1'b0}}};

    // configuration registers
    logic [LW-1:0] r_level_lo;
    logic [LW-1:0] r_level_hi;
    logic          r_premult;
    logic          w_cfg_wr;
    t_reg_idx      w_reg_idx;

    assign pready    = 1'b1;
    assign w_cfg_wr  = psel & penable & pwrite & pready;
    assign w_reg_idx = t_reg_idx'(paddr[3:2]);

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level_lo <= '0;
            r_level_hi <= ONE_VAL;
            r_premult  <= 1'b1;
        end else if (w_cfg_wr) begin
            case (w_reg_idx)
                REG_LEVEL_LO:      r_level_lo <= pwdata[LW-1:0];
                REG_LEVEL_HI:      r_level_hi <= pwdata[LW-1:0];
                REG_PREMULTIPLIED: r_premult  <= pwdata[0];
                default: ;
            endcase
        end
    end

    // register reads
    always_comb begin
        case (w_reg_idx)
            REG_LEVEL_LO:      prdata = PDATA_W'(r_level_lo);
            REG_LEVEL_HI:      prdata = PDATA_W'(r_level_hi);
            REG_PREMULTIPLIED: prdata = PDATA_W'(r_premult);
            default:           prdata = '0;
        endcase
    end

    // global pipeline advance
    logic w_en;
    logic r_out_v;

    assign o_stall = r_out_v & i_stall;
    assign w_en    = ~o_stall;
    assign o_valid = r_out_v;

    // ---------------- entry stage: alpha classification and ratio setup
    logic signed [EW-1:0] w_a_s;
    logic signed [EW-1:0] w_lo_s;
    logic signed [EW-1:0] w_hi_s;
    logic signed [EW-1:0] w_diff_s;
    logic [LW-1:0]        w_d;

    assign w_a_s    = EW'(i_alpha_in);
    assign w_lo_s   = EW'(r_level_lo);
    assign w_hi_s   = EW'(r_level_hi);
    assign w_diff_s = w_a_s - w_lo_s;
    assign w_d      = r_level_hi - r_level_lo;

    // alpha divider stages, index 0 is the entry stage
    logic           r_ad_v    [0:QA];
    logic [ANW-1:0] r_ad_rem  [0:QA];
    logic [QA-1:0]  r_ad_q    [0:QA];
    logic [LW:0]    r_ad_den  [0:QA];
    logic           r_ad_zero [0:QA];
    logic           r_ad_one  [0:QA];
    logic [C-1:0]   r_ad_a    [0:QA];
    logic [C-1:0]   r_ad_col  [0:QA][0:2];

    // entry register
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ad_rem[0]    <= (ANW'(w_diff_s[LW-1:0]) << (F + 1)) + ANW'(w_d);
            r_ad_q[0]      <= '0;
            r_ad_den[0]    <= {w_d, 1'b0};
            r_ad_zero[0]   <= (w_a_s <= w_lo_s);
            r_ad_one[0]    <= (w_a_s >= w_hi_s) || (r_level_lo == r_level_hi);
            r_ad_a[0]      <= i_alpha_in;
            r_ad_col[0][0] <= i_red_in;
            r_ad_col[0][1] <= i_green_in;
            r_ad_col[0][2] <= i_blue_in;
        end
    end

    // one alpha quotient bit per stage
    for (genvar j = 0; j < QA; j++) begin : g_adiv
        logic [ANW-1:0] w_sh;
        logic           w_ge;

        assign w_sh = ANW'(r_ad_den[j]) << (QA - 1 - j);
        assign w_ge = (r_ad_rem[j] >= w_sh);

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_ad_rem[j+1]    <= w_ge ? (r_ad_rem[j] - w_sh) : r_ad_rem[j];
                r_ad_q[j+1]      <= {r_ad_q[j][QA-2:0], w_ge};
                r_ad_den[j+1]    <= r_ad_den[j];
                r_ad_zero[j+1]   <= r_ad_zero[j];
                r_ad_one[j+1]    <= r_ad_one[j];
                r_ad_a[j+1]      <= r_ad_a[j];
                r_ad_col[j+1][0] <= r_ad_col[j][0];
                r_ad_col[j+1][1] <= r_ad_col[j][1];
                r_ad_col[j+1][2] <= r_ad_col[j][2];
            end
        end
    end

    // ---------------- new alpha and color products
    logic [LW-1:0] w_na;

    assign w_na = r_ad_zero[QA] ? '0 : (r_ad_one[QA] ? ONE_VAL : r_ad_q[QA][LW-1:0]);

    logic          r_m_v;
    logic [LW-1:0] r_m_na;
    logic [C-1:0]  r_m_a;
    logic [MW-1:0] r_m_prod [0:2];
    logic          r_m_neg  [0:2];
    logic [C-1:0]  r_m_col  [0:2];

    for (genvar k = 0; k < 3; k++) begin : g_mul
        logic [C-1:0] w_mag;

        assign w_mag = r_ad_col[QA][k][C-1] ? (~r_ad_col[QA][k] + C'(1)) : r_ad_col[QA][k];

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_m_prod[k] <= MW'(w_mag) * MW'(w_na);
                r_m_neg[k]  <= r_ad_col[QA][k][C-1];
                r_m_col[k]  <= r_ad_col[QA][k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m_na <= w_na;
            r_m_a  <= r_ad_a[QA];
        end
    end

    // ---------------- color divider, index 0 is the numerator setup stage
    logic           r_cd_v   [0:C];
    logic [C-1:0]   r_cd_den [0:C];
    logic [LW-1:0]  r_cd_na  [0:C];
    logic [CNW-1:0] r_cd_rem [0:C][0:2];
    logic [C-1:0]   r_cd_q   [0:C][0:2];
    logic           r_cd_sat [0:C][0:2];
    logic           r_cd_neg [0:C][0:2];
    logic [C-1:0]   r_cd_col [0:C][0:2];

    logic [C-1:0]   w_cden;

    // alpha is positive whenever the quotient is used
    assign w_cden = {r_m_a[C-2:0], 1'b0};

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_cd_den[0] <= w_cden;
            r_cd_na[0]  <= r_m_na;
        end
    end

    for (genvar k = 0; k < 3; k++) begin : g_cset
        logic [CNW-1:0] w_num;

        assign w_num = (CNW'(r_m_prod[k]) << 1) + CNW'(r_m_a[C-2:0]);

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_cd_rem[0][k] <= w_num;
                r_cd_q[0][k]   <= '0;
                r_cd_sat[0][k] <= (SW'(w_num) >= (SW'(w_cden) << C));
                r_cd_neg[0][k] <= r_m_neg[k];
                r_cd_col[0][k] <= r_m_col[k];
            end
        end
    end

    // one color quotient bit per stage for each channel
    for (genvar j = 0; j < C; j++) begin : g_cdiv
        logic [SW-1:0] w_sh;

        assign w_sh = SW'(r_cd_den[j]) << (C - 1 - j);

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_cd_den[j+1] <= r_cd_den[j];
                r_cd_na[j+1]  <= r_cd_na[j];
            end
        end

        for (genvar k = 0; k < 3; k++) begin : g_ch
            logic w_ge;

            assign w_ge = (SW'(r_cd_rem[j][k]) >= w_sh);

            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    r_cd_rem[j+1][k] <= w_ge ? (r_cd_rem[j][k] - CNW'(w_sh)) : r_cd_rem[j][k];
                    r_cd_q[j+1][k]   <= {r_cd_q[j][k][C-2:0], w_ge};
                    r_cd_sat[j+1][k] <= r_cd_sat[j][k];
                    r_cd_neg[j+1][k] <= r_cd_neg[j][k];
                    r_cd_col[j+1][k] <= r_cd_col[j][k];
                end
            end
        end
    end

    // ---------------- sign, saturation and mode select
    logic [C-1:0]  r_out_col [0:2];
    logic [LW-1:0] r_out_na;

    for (genvar k = 0; k < 3; k++) begin : g_fin
        logic [C-1:0] w_q;
        logic [C-1:0] w_res;

        assign w_q = r_cd_q[C][k];

        always_comb begin
            if (!r_premult) begin
                w_res = r_cd_col[C][k];
            end else if (r_cd_na[C] == '0) begin
                w_res = '0;
            end else if (!r_cd_neg[C][k]) begin
                w_res = (r_cd_sat[C][k] || w_q[C-1]) ? CH_MAX : w_q;
            end else if (r_cd_sat[C][k] || (w_q[C-1] && (|w_q[C-2:0]))) begin
                w_res = CH_MIN;
            end else begin
                w_res = ~w_q + C'(1);
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_out_col[k] <= w_res;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_na <= r_cd_na[C];
        end
    end

    assign o_red_out   = r_out_col[0];
    assign o_green_out = r_out_col[1];
    assign o_blue_out  = r_out_col[2];
    assign o_alpha_out = r_out_na;

    // ---------------- valid bits travel with the words
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ad_v[0] <= 1'b0;
            r_m_v     <= 1'b0;
            r_cd_v[0] <= 1'b0;
            r_out_v   <= 1'b0;
        end else if (w_en) begin
            r_ad_v[0] <= i_valid;
            r_m_v     <= r_ad_v[QA];
            r_cd_v[0] <= r_m_v;
            r_out_v   <= r_cd_v[C];
        end
    end

    for (genvar j = 0; j < QA; j++) begin : g_av
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ad_v[j+1] <= 1'b0;
            end else if (w_en) begin
                r_ad_v[j+1] <= r_ad_v[j];
            end
        end
    end

    for (genvar j = 0; j < C; j++) begin : g_cv
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_cd_v[j+1] <= 1'b0;
            end else if (w_en) begin
                r_cd_v[j+1] <= r_cd_v[j];
            end
        end
    end

endmodule

### rtl/core/alru_checker.sv
// port-level checks of the alpha levels remap unit and their bind
`include "alpha_levels_remap_unit_macros.svh"

module alru_checker #(
    parameter int FRAC_BITS = 12
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_stall,
    input logic               o_valid,
    input logic               i_stall,
    input logic [FRAC_BITS:0] o_alpha_out
);
    import alru_pkg::*;

    localparam logic [FRAC_BITS:0] ONE_VAL = (FRAC_BITS + 1)'(1) << FRAC_BITS;

    // a held output word stays offered
    `ALRU_ASSERT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall |=> o_valid, "output word dropped while stalled")
    // input is held back only while the output word waits
    `ALRU_ASSERT(a_stall_cause, i_clk, i_rst_n, o_stall |-> (o_valid && i_stall), "input stalled without output backpressure")
    // remapped alpha never exceeds one
    `ALRU_ASSERT(a_alpha_range, i_clk, i_rst_n, o_valid |-> (o_alpha_out <= ONE_VAL), "alpha out of range")
    // reset empties the pipeline
    `ALRU_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !o_valid, "output valid right after reset")

endmodule

bind alpha_levels_remap_unit alru_checker #(
    .FRAC_BITS(FRAC_BITS)
) u_alru_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_valid    (i_valid),
    .o_stall    (o_stall),
    .o_valid    (o_valid),
    .i_stall    (i_stall),
    .o_alpha_out(o_alpha_out)
);
